### rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types, codes and microcode for the infix to postfix converter
// Holds operator codes, precedence, the control word layout and the control
// program that the sequencer in the top level steps through.
// ----------------------------------------------------------------------------
package itp_pkg;

    // Operator codes as held on the stack
    typedef logic [2:0] t_code;
    localparam t_code CODE_LPAR = 3'd0;
    localparam t_code CODE_ADD  = 3'd1;
    localparam t_code CODE_SUB  = 3'd2;
    localparam t_code CODE_MUL  = 3'd3;
    localparam t_code CODE_DIV  = 3'd4;
    localparam t_code CODE_POW  = 3'd5;

    // Sequencer step addresses
    typedef logic [3:0] t_step;
    localparam t_step ST_FETCH  = 4'd0;
    localparam t_step ST_LETTER = 4'd1;
    localparam t_step ST_LPAR   = 4'd2;
    localparam t_step ST_RPAR   = 4'd3;
    localparam t_step ST_RDROP  = 4'd4;
    localparam t_step ST_OP     = 4'd5;
    localparam t_step ST_OPPUSH = 4'd6;
    localparam t_step ST_END    = 4'd7;
    localparam t_step ST_TERM   = 4'd8;

    // Step condition select
    localparam logic [1:0] COND_ALWAYS   = 2'd0;
    localparam logic [1:0] COND_NONEMPTY = 2'd1;
    localparam logic [1:0] COND_RPOP     = 2'd2;
    localparam logic [1:0] COND_OPOP     = 2'd3;

    // Emit source select
    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_CH   = 2'd1;
    localparam logic [1:0] EMIT_TOP  = 2'd2;
    localparam logic [1:0] EMIT_TERM = 2'd3;

    // Last-beat flag select
    localparam logic [1:0] LAST_ZERO = 2'd0;
    localparam logic [1:0] LAST_ONE  = 2'd1;
    localparam logic [1:0] LAST_RPAR = 2'd2;
    localparam logic [1:0] LAST_OP   = 2'd3;

    typedef struct packed {
        logic [1:0] cond;
        logic [1:0] emit;
        logic [1:0] last;
        logic       pop;
        logic       push;
        logic       clr_ovf;
        t_step      nxt_t;
        t_step      nxt_f;
    } t_uword;

    // Stack control and status between sequencer and stack
    typedef struct packed {
        logic  push;
        logic  pop;
        t_code code;
    } t_stk_ctl;

    typedef struct packed {
        t_code top;
        t_code below;
    } t_stk_stat;

    function automatic logic [1:0] code_prec(input t_code c);
        logic [1:0] p;
        unique case (c)
            CODE_ADD, CODE_SUB: p = 2'd1;
            CODE_MUL, CODE_DIV: p = 2'd2;
            CODE_POW:           p = 2'd3;
            default:            p = 2'd0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] code_char(input t_code c);
        logic [7:0] ch;
        unique case (c)
            CODE_LPAR: ch = 8'h28;
            CODE_ADD:  ch = 8'h2B;
            CODE_SUB:  ch = 8'h2D;
            CODE_MUL:  ch = 8'h2A;
            CODE_DIV:  ch = 8'h2F;
            CODE_POW:  ch = 8'h5E;
            default:   ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Does incoming operator 'op' pop stacked entry 'stk'? '^' is right-assoc.
    function automatic logic op_pops(input t_code op, input t_code stk);
        logic r;
        if (op == CODE_POW) begin
            r = code_prec(stk) > code_prec(op);
        end else begin
            r = code_prec(stk) >= code_prec(op);
        end
        return r;
    endfunction

    // Entry step for an accepted beat
    function automatic t_step entry_step(input logic kind, input logic [7:0] ch);
        t_step s;
        if (kind) begin
            s = ST_END;
        end else if (ch == 8'h28) begin
            s = ST_LPAR;
        end else if (ch == 8'h29) begin
            s = ST_RPAR;
        end else if (ch == 8'h2B || ch == 8'h2D || ch == 8'h2A || ch == 8'h2F
                     || ch == 8'h5E) begin
            s = ST_OP;
        end else if ((ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A)) begin
            s = ST_LETTER;
        end else begin
            s = ST_FETCH;
        end
        return s;
    endfunction

    function automatic t_code char_code(input logic [7:0] ch);
        t_code c;
        unique case (ch)
            8'h2B:   c = CODE_ADD;
            8'h2D:   c = CODE_SUB;
            8'h2A:   c = CODE_MUL;
            8'h2F:   c = CODE_DIV;
            8'h5E:   c = CODE_POW;
            default: c = CODE_LPAR;
        endcase
        return c;
    endfunction

    // Control program. Action fields apply only when the step condition holds.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            ST_LETTER: w = '{COND_ALWAYS, EMIT_CH, LAST_ONE, 1'b0, 1'b0, 1'b0,
                             ST_FETCH, ST_FETCH};
            ST_LPAR:   w = '{COND_ALWAYS, EMIT_NONE, LAST_ZERO, 1'b0, 1'b1, 1'b0,
                             ST_FETCH, ST_FETCH};
            ST_RPAR:   w = '{COND_RPOP, EMIT_TOP, LAST_RPAR, 1'b1, 1'b0, 1'b0,
                             ST_RPAR, ST_RDROP};
            ST_RDROP:  w = '{COND_NONEMPTY, EMIT_NONE, LAST_ZERO, 1'b1, 1'b0, 1'b0,
                             ST_FETCH, ST_FETCH};
            ST_OP:     w = '{COND_OPOP, EMIT_TOP, LAST_OP, 1'b1, 1'b0, 1'b0,
                             ST_OP, ST_OPPUSH};
            ST_OPPUSH: w = '{COND_ALWAYS, EMIT_NONE, LAST_ZERO, 1'b0, 1'b1, 1'b0,
                             ST_FETCH, ST_FETCH};
            ST_END:    w = '{COND_NONEMPTY, EMIT_TOP, LAST_ZERO, 1'b1, 1'b0, 1'b0,
                             ST_END, ST_TERM};
            ST_TERM:   w = '{COND_ALWAYS, EMIT_TERM, LAST_ONE, 1'b0, 1'b0, 1'b1,
                             ST_FETCH, ST_FETCH};
            default:   w = '{COND_ALWAYS, EMIT_NONE, LAST_ZERO, 1'b0, 1'b0, 1'b0,
                             ST_FETCH, ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

### rtl/itp_in_if.sv
// ----------------------------------------------------------------------------
// itp_in_if: input channel of the infix to postfix converter
// Valid/ready channel carrying one infix character or an end mark per beat.
// ----------------------------------------------------------------------------
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] ch;

    modport source (output valid, output kind, output ch, input ready);
    modport sink   (input valid, input kind, input ch, output ready);
endinterface

### rtl/itp_out_if.sv
// ----------------------------------------------------------------------------
// itp_out_if: output channel of the infix to postfix converter
// Valid/ready channel carrying one postfix character per beat.
// ----------------------------------------------------------------------------
interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_last;
    logic       expr_end;
    logic       overflow;

    modport source (output valid, output out_char, output run_last,
                    output expr_end, output overflow, input ready);
    modport sink   (input valid, input out_char, input run_last,
                    input expr_end, input overflow, output ready);
endinterface

### rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Microcoded sequencer over an operator stack and an output register.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  (sink)  : one beat per infix character (kind 0) or end mark (kind 1).
//   o_out (source): postfix characters; run_last marks the last beat caused
//                   by an input beat, expr_end marks the terminator (char 0)
//                   and overflow reports a dropped push since the last end.
// Sequencing:
//   Fetch takes an input beat; a new beat is taken only in the fetch step.
//   Then one step runs per cycle unless an emitting step stalls: a letter
//   is emitted, a '(' is pushed, an operator or ')' pops while its pop test
//   holds, then pushes the operator or drops the '(', and an end mark
//   flushes the stack, then emits the terminator. A letter is loaded into
//   the output register by the step after the fetch that accepts it, unless
//   that step stalls. Other characters are dropped at fetch, with no beat.
// Reset:
//   Clears the stack count, the overflow flag, the output valid flag and the
//   step counter. Stack memory is not cleared; only live entries are read.
// Backpressure:
//   A step that emits holds while the output register is full and not being
//   drained; the register frees in the cycle its beat is taken.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input logic          i_clk,
    input logic          i_rst_n,
    itp_in_if.sink       i_in,
    itp_out_if.source    o_out
);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer state
    itp_pkg::t_step  r_upc;
    itp_pkg::t_step  n_upc;
    logic [7:0]      r_ch;
    itp_pkg::t_code  r_code;
    logic            r_ovf;

    // Output register
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_out_last;
    logic            r_out_end;
    logic            r_out_ovf;

    // Stack interface
    itp_pkg::t_stk_ctl  stk_ctl;
    itp_pkg::t_stk_stat stk_stat;
    logic [CW-1:0]      stk_count;
    logic               stk_full;

    itp_pkg::t_uword uw;
    logic            in_fire;
    logic            nonempty;
    logic            cond_ok;
    logic            slot_free;
    logic            stall;
    logic            act;
    logic            emit_fire;
    logic [7:0]      emit_char;
    logic            emit_last;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_stat  (stk_stat),
        .o_count (stk_count),
        .o_full  (stk_full)
    );

    // Control word for the current step
    assign uw       = itp_pkg::ucode(r_upc);
    assign nonempty = (stk_count != '0);

    assign i_in.ready = (r_upc == itp_pkg::ST_FETCH);
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        unique case (uw.cond)
            itp_pkg::COND_ALWAYS:   cond_ok = 1'b1;
            itp_pkg::COND_NONEMPTY: cond_ok = nonempty;
            itp_pkg::COND_RPOP:     cond_ok = nonempty
                                              && (stk_stat.top != itp_pkg::CODE_LPAR);
            itp_pkg::COND_OPOP:     cond_ok = nonempty
                                              && itp_pkg::op_pops(r_code, stk_stat.top);
            default:                cond_ok = 1'b0;
        endcase
    end

    // An emitting step holds until the output register can take the beat
    assign slot_free = !r_out_valid || o_out.ready;
    assign stall     = cond_ok && (uw.emit != itp_pkg::EMIT_NONE) && !slot_free;
    assign act       = (r_upc != itp_pkg::ST_FETCH) && cond_ok && !stall;
    assign emit_fire = act && (uw.emit != itp_pkg::EMIT_NONE);

    always_comb begin
        unique case (uw.emit)
            itp_pkg::EMIT_CH:  emit_char = r_ch;
            itp_pkg::EMIT_TOP: emit_char = itp_pkg::code_char(stk_stat.top);
            default:           emit_char = 8'h00;
        endcase
    end

    // Last beat of this input: after a pop, check what the next top does
    always_comb begin
        unique case (uw.last)
            itp_pkg::LAST_ONE:  emit_last = 1'b1;
            itp_pkg::LAST_RPAR: emit_last = (stk_count == CW'(1))
                                            || (stk_stat.below == itp_pkg::CODE_LPAR);
            itp_pkg::LAST_OP:   emit_last = (stk_count == CW'(1))
                                            || !itp_pkg::op_pops(r_code, stk_stat.below);
            default:            emit_last = 1'b0;
        endcase
    end

    assign stk_ctl.push = act && uw.push;
    assign stk_ctl.pop  = act && uw.pop;
    assign stk_ctl.code = r_code;

    // Step counter: dispatch in fetch, hold on stall, else branch on condition
    always_comb begin
        if (r_upc == itp_pkg::ST_FETCH) begin
            n_upc = in_fire ? itp_pkg::entry_step(i_in.kind, i_in.ch) : itp_pkg::ST_FETCH;
        end else if (stall) begin
            n_upc = r_upc;
        end else begin
            n_upc = cond_ok ? uw.nxt_t : uw.nxt_f;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= itp_pkg::ST_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ch   <= i_in.ch;
            r_code <= i_in.kind ? itp_pkg::CODE_LPAR : itp_pkg::char_code(i_in.ch);
        end
    end

    // Sticky overflow: set on a dropped push, clear after the terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf <= 1'b0;
        end else if (act && uw.clr_ovf) begin
            r_ovf <= 1'b0;
        end else if (stk_ctl.push && stk_full) begin
            r_ovf <= 1'b1;
        end
    end

    // Output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_fire) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
            r_out_end  <= (uw.emit == itp_pkg::EMIT_TERM);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_char = r_out_char;
    assign o_out.run_last = r_out_last;
    assign o_out.expr_end = r_out_end;
    assign o_out.overflow = r_out_ovf;

    // Stack never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // The terminator goes out only once the stack is drained
    a_term_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && uw.emit == itp_pkg::EMIT_TERM) |-> !nonempty)
        else $error("terminator with stack not empty");

    // Overflow flag is clear right after a terminator
    a_ovf_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_fire && uw.emit == itp_pkg::EMIT_TERM) |=> !r_ovf)
        else $error("overflow not cleared at end");

    // A pop is only issued on a non-empty stack
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_ctl.pop |-> nonempty)
        else $error("pop on empty stack");
endmodule

### rtl/itp_stack.sv
// ----------------------------------------------------------------------------
// itp_stack: operator stack
// Memory-backed stack with the top entry and the entry below it held in
// registers, so a pop completes at the next clock edge.
// ----------------------------------------------------------------------------
module itp_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  itp_pkg::t_stk_ctl    i_ctl,
    output itp_pkg::t_stk_stat   o_stat,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_count,
    output logic                 o_full
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    itp_pkg::t_code r_mem [STACK_DEPTH];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;
    logic [CW-1:0]  rd_ptr;
    itp_pkg::t_code r_top;
    itp_pkg::t_code r_below;
    logic           full;
    logic           do_push;

    assign full    = (r_count == CW'(STACK_DEPTH));
    assign do_push = i_ctl.push && !full;

    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // Entry just below the new top; meaningless while fewer than two entries
    assign rd_ptr = n_count - CW'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_count[AW-1:0]] <= i_ctl.code;
        end
        r_below <= r_mem[rd_ptr[AW-1:0]];
    end

    // Hold a copy of the top entry
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_top <= i_ctl.code;
        end else if (i_ctl.pop) begin
            r_top <= r_below;
        end
    end

    assign o_stat.top   = r_top;
    assign o_stat.below = r_below;
    assign o_count      = r_count;
    assign o_full       = full;
endmodule
